@@ src/shfc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shfc_pkg: shared types and constants for the sync header frame checker
// Header bytes, sync phase codes, frame positions and the result flag bundle.
// ----------------------------------------------------------------------------
package shfc_pkg;

    localparam int FRAME_BYTES = 12;

    localparam logic [7:0] HEAD_FIRST  = 8'hAA;
    localparam logic [7:0] HEAD_SECOND = 8'h55;

    // sync phase codes
    localparam logic [1:0] PHASE_HUNT = 2'd0;
    localparam logic [1:0] PHASE_HEAD = 2'd1;
    localparam logic [1:0] PHASE_BODY = 2'd2;

    // frame byte positions
    localparam logic [3:0] POS_HEAD1   = 4'd1;
    localparam logic [3:0] POS_BODY0   = 4'd2;
    localparam logic [3:0] POS_CHK_HI  = 4'(FRAME_BYTES - 2);
    localparam logic [3:0] POS_CHK_LO  = 4'(FRAME_BYTES - 1);

    localparam logic [30:0] LIMIT_RESET = 31'h3FC0_0000;
    localparam logic [30:0] INF_BITS    = 31'h7F80_0000;

    typedef struct packed {
        logic checksum_ok;
        logic first_in_range;
    } result_flags_t;

endpackage
`default_nettype wire

@@ src/shfc_result_calc.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shfc_result_calc: frame verdict logic
// Checksum compare and range test of the first word, done on the final byte.
// ----------------------------------------------------------------------------
module shfc_result_calc (
    input  wire logic [15:0]          running_sum,
    input  wire logic [7:0]           checksum_high,
    input  wire logic [7:0]           checksum_low,
    input  wire logic [31:0]          first_word,
    input  wire logic [30:0]          range_limit,
    output shfc_pkg::result_flags_t   flags
);

    logic [30:0] mag;

    assign mag = first_word[30:0];

    always_comb begin
        flags.checksum_ok    = ({checksum_high, checksum_low} == running_sum);
        // NaN codes sit above infinity, so a limit past infinity still rejects them
        flags.first_in_range = (mag <= shfc_pkg::INF_BITS) && (mag <= range_limit);
    end

endmodule
`default_nettype wire

@@ src/sync_header_frame_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sync_header_frame_checker: byte-stream frame sync with additive checksum
//
// s_ channel: one received byte per transfer (s_rx_byte). The block hunts for
// the header 0xAA 0x55, then collects ten more bytes for a 12-byte frame.
// A byte that breaks the header is dropped and the hunt restarts at 0xAA.
// m_ channel: one transfer per complete frame with both little-endian payload
// words, the 16-bit checksum verdict and the range flag of the first word.
// cfg channel: writes the 31-bit magnitude limit (IEEE single bits); always
// ready, write only while no frame is in flight. Reset value is 1.5.
// Throughput: one byte per cycle while s_ready is high. Each byte updates the
// frame state in the cycle it is taken; the result of a frame is valid on m_
// the cycle after its last byte transfers.
// One output register holds the result. While it is full and m_ready is low,
// s_ready drops, so a stalled receiver stops the byte stream; s_ready is
// high whenever the register is empty or being drained in the same cycle.
// Reset (aresetn low, synchronous): hunt phase, empty output, default limit.
// ----------------------------------------------------------------------------
module sync_header_frame_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // byte input
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_rx_byte,
    // frame result
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_checksum_ok,
    output logic [31:0]      m_first_word,
    output logic [31:0]      m_second_word,
    output logic             m_first_in_range,
    // limit register write
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [30:0] cfg_data
);

    // frame state
    logic [1:0]  phase_reg, phase_next;
    logic [3:0]  count_reg, count_next;
    logic [15:0] sum_reg, sum_next;
    logic [7:0]  payload_reg [8];
    logic [7:0]  chk_hi_reg;
    logic [30:0] limit_reg;

    // result register
    logic        m_valid_reg, m_valid_next;
    logic        m_checksum_ok_reg;
    logic [31:0] m_first_word_reg;
    logic [31:0] m_second_word_reg;
    logic        m_first_in_range_reg;

    logic        s_fire;
    logic        in_body;
    logic        payload_wr;
    logic        chk_hi_wr;
    logic        frame_done;
    logic [3:0]  lane_off;
    logic [2:0]  lane;
    logic [31:0] first_word;
    logic [31:0] second_word;

    shfc_pkg::result_flags_t flags;

    assign s_ready   = !m_valid_reg || m_ready;
    assign cfg_ready = 1'b1;
    assign s_fire    = s_valid && s_ready;

    assign in_body    = (phase_reg == shfc_pkg::PHASE_BODY);
    assign payload_wr = s_fire && in_body && (count_reg < shfc_pkg::POS_CHK_HI);
    assign chk_hi_wr  = s_fire && in_body && (count_reg == shfc_pkg::POS_CHK_HI);
    assign frame_done = s_fire && in_body && (count_reg == shfc_pkg::POS_CHK_LO);

    // payload byte 2 lands in lane 0
    assign lane_off = count_reg - shfc_pkg::POS_BODY0;
    assign lane     = lane_off[2:0];

    assign first_word  = {payload_reg[3], payload_reg[2], payload_reg[1], payload_reg[0]};
    assign second_word = {payload_reg[7], payload_reg[6], payload_reg[5], payload_reg[4]};

    shfc_result_calc u_calc (
        .running_sum   (sum_reg),
        .checksum_high (chk_hi_reg),
        .checksum_low  (s_rx_byte),
        .first_word    (first_word),
        .range_limit   (limit_reg),
        .flags         (flags)
    );

    // sync / collect sequencing
    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        if (s_fire) begin
            case (phase_reg)
                shfc_pkg::PHASE_HEAD: begin
                    if (s_rx_byte == shfc_pkg::HEAD_SECOND) begin
                        phase_next = shfc_pkg::PHASE_BODY;
                        count_next = shfc_pkg::POS_BODY0;
                    end else begin
                        phase_next = shfc_pkg::PHASE_HUNT;
                        count_next = '0;
                        sum_next   = '0;
                    end
                end
                shfc_pkg::PHASE_BODY: begin
                    if (count_reg == shfc_pkg::POS_CHK_LO) begin
                        phase_next = shfc_pkg::PHASE_HUNT;
                        count_next = '0;
                        sum_next   = '0;
                    end else begin
                        count_next = count_reg + 4'd1;
                        if (count_reg < shfc_pkg::POS_CHK_HI) begin
                            sum_next = sum_reg + {8'd0, s_rx_byte};
                        end
                    end
                end
                default: begin
                    // hunting; the unused code behaves the same
                    if (s_rx_byte == shfc_pkg::HEAD_FIRST) begin
                        phase_next = shfc_pkg::PHASE_HEAD;
                        count_next = shfc_pkg::POS_HEAD1;
                    end else begin
                        phase_next = shfc_pkg::PHASE_HUNT;
                        count_next = '0;
                        sum_next   = '0;
                    end
                end
            endcase
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (frame_done) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= shfc_pkg::PHASE_HUNT;
            count_reg   <= '0;
            sum_reg     <= '0;
            m_valid_reg <= 1'b0;
            limit_reg   <= shfc_pkg::LIMIT_RESET;
        end else begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                limit_reg <= cfg_data;
            end
        end
    end

    // payload and result data, no reset needed
    always_ff @(posedge aclk) begin
        if (payload_wr) begin
            payload_reg[lane] <= s_rx_byte;
        end
        if (chk_hi_wr) begin
            chk_hi_reg <= s_rx_byte;
        end
        if (frame_done) begin
            m_checksum_ok_reg    <= flags.checksum_ok;
            m_first_word_reg     <= first_word;
            m_second_word_reg    <= second_word;
            m_first_in_range_reg <= flags.first_in_range;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_checksum_ok    = m_checksum_ok_reg;
    assign m_first_word     = m_first_word_reg;
    assign m_second_word    = m_second_word_reg;
    assign m_first_in_range = m_first_in_range_reg;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_hunt_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == shfc_pkg::PHASE_HUNT) |-> (count_reg == 4'd0 && sum_reg == 16'd0))
        else $error("hunt phase with stale count or sum");

    a_body_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == shfc_pkg::PHASE_BODY) |->
            (count_reg >= shfc_pkg::POS_BODY0 && count_reg <= shfc_pkg::POS_CHK_LO))
        else $error("frame byte count out of range");

    a_done_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_done |=> (m_valid_reg && phase_reg == shfc_pkg::PHASE_HUNT))
        else $error("finished frame did not produce a result");

    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid_reg && !m_ready))
        else $error("input stalled without a blocked result");

endmodule
`default_nettype wire
